// ----- hw/rtl/bmp24_pixel_sum_unit_assert.svh -----
// ----------------------------------------------------------------------------
// BMP24 pixel sum assertion macros
// Shorthand for clocked assertions; the user module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef BMP24_PIXEL_SUM_UNIT_ASSERT_SVH
`define BMP24_PIXEL_SUM_UNIT_ASSERT_SVH

// Same-cycle implication
`define BMP24_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BMP24_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bmp24_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP24 pixel sum package
// Shared widths, header offsets, status codes, phase codes and structs.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Result widths
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned STATUS_W = 3;

  // Header constants
  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [31:0] HEADER_END    = 32'd30;

  // Header byte positions
  localparam logic [4:0] FIRST_POS    = 5'd0;
  localparam logic [4:0] SIG_HI_POS   = 5'd1;
  localparam logic [4:0] OFFSET_POS   = 5'd10;
  localparam logic [4:0] WIDTH_POS    = 5'd18;
  localparam logic [4:0] HEIGHT_POS   = 5'd22;
  localparam logic [4:0] DEPTH_POS    = 5'd28;
  localparam logic [4:0] DEPTH_HI_POS = 5'd29;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOT_BMP = 3'd1,
    ST_DEPTH   = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_GEOM    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [SUM_W-1:0] pixel_sum;
    status_t          status;
  } result_t;

  // Header decode flags, handed from the header parser to the sequencer
  typedef struct packed {
    logic sig_bad;
    logic depth_bad;
    logic geom_bad;
    logic empty;
    logic direct;
  } hdr_flags_t;

endpackage

// ----- hw/rtl/bmp24_in_if.sv -----
// ----------------------------------------------------------------------------
// BMP24 byte channel
// Valid/ready channel carrying one file byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface bmp24_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

// ----- hw/rtl/bmp24_out_if.sv -----
// ----------------------------------------------------------------------------
// BMP24 result channel
// Valid/ready channel carrying the pixel sum and status of one file.
// ----------------------------------------------------------------------------
interface bmp24_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmp24_pkg::SUM_W-1:0]   pixel_sum;
  logic [bmp24_pkg::STATUS_W-1:0] status;

  modport source (output valid, output pixel_sum, output status, input ready);
  modport sink   (input valid, input pixel_sum, input status, output ready);
endinterface

// ----- hw/rtl/bmp24_hdr.sv -----
// ----------------------------------------------------------------------------
// BMP24 header parser
// Captures offset, width, height and depth bytes and decodes the header checks.
// ----------------------------------------------------------------------------
module bmp24_hdr #(
  parameter int unsigned MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned RowW  = $clog2(3 * MAX_WIDTH + 4),
  localparam int unsigned RowsW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                    clk,
  input  logic                    take,
  input  logic [4:0]              pos,
  input  logic [7:0]              file_byte,
  output bmp24_pkg::hdr_flags_t   flags,
  output logic [31:0]             pixel_start,
  output logic [RowW-1:0]         width_x3,
  output logic [RowW-1:0]         row_len,
  output logic [RowsW-1:0]        row_count
);
  import bmp24_pkg::*;

  logic [7:0]      depth_lo;
  logic [31:0]     image_width;
  logic [31:0]     image_height;
  logic [1:0]      lane_off;
  logic [1:0]      lane_wid;
  logic [1:0]      lane_hgt;
  logic [15:0]     word16;
  logic [31:0]     habs;
  logic [RowW-1:0] w_trunc;

  // Byte lanes inside each little-endian field
  assign lane_off = 2'(pos - OFFSET_POS);
  assign lane_wid = 2'(pos - WIDTH_POS);
  assign lane_hgt = 2'(pos - HEIGHT_POS);

  // Field capture
  always_ff @(posedge clk) begin
    if (take) begin
      if (pos == FIRST_POS || pos == DEPTH_POS) begin
        depth_lo <= file_byte;
      end
      if (pos >= OFFSET_POS && pos < OFFSET_POS + 5'd4) begin
        pixel_start[{lane_off, 3'b000} +: 8] <= file_byte;
      end
      if (pos >= WIDTH_POS && pos < WIDTH_POS + 5'd4) begin
        image_width[{lane_wid, 3'b000} +: 8] <= file_byte;
      end
      if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 5'd4) begin
        image_height[{lane_hgt, 3'b000} +: 8] <= file_byte;
      end
    end
  end

  // Checks: signature at byte 1, depth and geometry at the last header byte
  assign word16 = {file_byte, depth_lo};
  assign habs   = image_height[31] ? (~image_height + 32'd1) : image_height;

  assign flags.sig_bad   = (word16 != BMP_SIGNATURE);
  assign flags.depth_bad = (word16 != DEPTH_24);
  assign flags.geom_bad  = image_width[31] || (image_width > 32'(MAX_WIDTH)) ||
                           (habs > 32'(MAX_HEIGHT)) || (pixel_start < HEADER_END);
  assign flags.empty     = (image_width == 32'd0) || (habs == 32'd0);
  assign flags.direct    = (pixel_start == HEADER_END);

  // Row geometry, meaningful only once the checks pass
  assign w_trunc   = image_width[RowW-1:0];
  assign width_x3  = w_trunc + {w_trunc[RowW-2:0], 1'b0};
  assign row_len   = (width_x3 + RowW'(3)) & ~RowW'(3);
  assign row_count = habs[RowsW-1:0];

endmodule

// ----- hw/rtl/bmp24_out_reg.sv -----
// ----------------------------------------------------------------------------
// BMP24 result register
// Holds one result until the receiver takes it; frees the slot in the same cycle.
// ----------------------------------------------------------------------------
module bmp24_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bmp24_pkg::result_t   data,
  output logic                 room,
  bmp24_out_if.source          result
);
  import bmp24_pkg::*;

  logic    valid;
  result_t hold;

  // Slot is free when empty or being drained this cycle
  assign room = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign result.valid     = valid;
  assign result.pixel_sum = hold.pixel_sum;
  assign result.status    = hold.status;

endmodule

// ----- hw/rtl/bmp24_pixel_sum_unit.sv -----
// ----------------------------------------------------------------------------
// BMP24 pixel sum unit
// Streams the bytes of a 24-bit BMP file and reports the sum of its pixel bytes.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one file byte per request, end_of_file set on the last byte.
//   result : one request per file, pixel_sum and status (0 ok, 1 not BMP,
//            2 depth not 24, 3 truncated, 4 unsupported geometry).
//   One byte is taken per cycle while stream is ready; each byte is fully
//   handled in the cycle it is accepted, so throughput is one byte per
//   cycle for every phase. A result is registered and appears on result in
//   the cycle after the byte that completes it (signature byte, last header
//   byte, last padded pixel byte, or an early end_of_file).
//   The result register decouples the sides: stream stays ready while the
//   slot is empty or being drained; only a held result with result.ready
//   low stalls stream.
//   Bytes after a result are dropped until end_of_file, which rearms the
//   unit for the next file. Synchronous reset returns to the header phase
//   with no result pending.
// ----------------------------------------------------------------------------
`include "bmp24_pixel_sum_unit_assert.svh"

module bmp24_pixel_sum_unit #(
  parameter int unsigned MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bmp24_in_if.sink    stream,
  bmp24_out_if.source result
);
  import bmp24_pkg::*;

  localparam int unsigned RowW  = $clog2(3 * MAX_WIDTH + 4);
  localparam int unsigned RowsW = $clog2(MAX_HEIGHT + 1);

  // Sequencer state
  phase_t           phase, phase_next;
  logic [31:0]      byte_position, byte_position_next;
  logic [RowW-1:0]  row_byte_index, row_byte_index_next;
  logic [RowsW-1:0] rows_done, rows_done_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;

  // Row geometry latched at the end of the header
  logic [RowW-1:0]  width_x3;
  logic [RowW-1:0]  row_len;
  logic [RowsW-1:0] row_count;

  hdr_flags_t       flags;
  logic [31:0]      pixel_start;
  logic [RowW-1:0]  hdr_width_x3;
  logic [RowW-1:0]  hdr_row_len;
  logic [RowsW-1:0] hdr_row_count;

  logic             acc;
  logic             room;
  logic             emit;
  logic             load_geom;
  status_t          st;
  logic [SUM_W-1:0] sum_upd;
  logic [RowW-1:0]  rbi_inc;
  logic [31:0]      pos_inc;
  result_t          res;

  assign acc          = stream.valid && stream.ready;
  assign stream.ready = room;
  assign rbi_inc      = row_byte_index + RowW'(1);
  assign pos_inc      = byte_position + 32'd1;

  bmp24_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk         (clk),
    .take        (acc && phase == PH_HEADER),
    .pos         (byte_position[4:0]),
    .file_byte   (stream.file_byte),
    .flags       (flags),
    .pixel_start (pixel_start),
    .width_x3    (hdr_width_x3),
    .row_len     (hdr_row_len),
    .row_count   (hdr_row_count)
  );

  // Per-byte update
  always_comb begin
    emit                = 1'b0;
    st                  = ST_OK;
    load_geom           = 1'b0;
    phase_next          = phase;
    byte_position_next  = byte_position;
    row_byte_index_next = row_byte_index;
    rows_done_next      = rows_done;
    sum_upd             = running_sum;

    case (phase)
      PH_HEADER: begin
        byte_position_next = pos_inc;
        if (byte_position[4:0] == SIG_HI_POS && flags.sig_bad) begin
          emit = 1'b1;
          st   = ST_NOT_BMP;
        end else if (byte_position[4:0] == DEPTH_HI_POS) begin
          if (flags.depth_bad) begin
            emit = 1'b1;
            st   = ST_DEPTH;
          end else if (flags.geom_bad) begin
            emit = 1'b1;
            st   = ST_GEOM;
          end else if (flags.empty) begin
            emit = 1'b1;
            st   = ST_OK;
          end else begin
            load_geom           = 1'b1;
            row_byte_index_next = '0;
            rows_done_next      = '0;
            sum_upd             = '0;
            phase_next          = flags.direct ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        byte_position_next = pos_inc;
        if (pos_inc == pixel_start) begin
          phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        // Color bytes only; padding is counted but not summed
        if (row_byte_index < width_x3) begin
          sum_upd = running_sum + SUM_W'(stream.file_byte);
        end
        if (rbi_inc == row_len) begin
          row_byte_index_next = '0;
          rows_done_next      = rows_done + RowsW'(1);
          if (rows_done + RowsW'(1) == row_count) begin
            emit = 1'b1;
            st   = ST_OK;
          end
        end else begin
          row_byte_index_next = rbi_inc;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // Early end of file
    if (!emit && stream.end_of_file && phase != PH_DONE) begin
      emit = 1'b1;
      st   = ST_TRUNC;
    end
    if (emit) begin
      phase_next = PH_DONE;
    end

    res.status    = st;
    res.pixel_sum = (st == ST_OK) ? sum_upd : '0;

    running_sum_next = sum_upd;
    // End of file rearms for the next file
    if (stream.end_of_file) begin
      phase_next          = PH_HEADER;
      byte_position_next  = '0;
      row_byte_index_next = '0;
      rows_done_next      = '0;
      running_sum_next    = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_position  <= '0;
      row_byte_index <= '0;
      rows_done      <= '0;
      running_sum    <= '0;
    end else if (acc) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      row_byte_index <= row_byte_index_next;
      rows_done      <= rows_done_next;
      running_sum    <= running_sum_next;
    end
  end

  // Geometry registers
  always_ff @(posedge clk) begin
    if (acc && load_geom) begin
      width_x3  <= hdr_width_x3;
      row_len   <= hdr_row_len;
      row_count <= hdr_row_count;
    end
  end

  bmp24_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (acc && emit),
    .data   (res),
    .room   (room),
    .result (result)
  );

  // Checks
  `BMP24_ASSERT_IMPL(a_err_sum_zero, result.valid && result.status != ST_OK, result.pixel_sum == '0, "error result with nonzero sum")
  `BMP24_ASSERT_IMPL(a_status_range, result.valid, result.status <= ST_GEOM, "status code out of range")
  `BMP24_ASSERT_IMPL(a_row_bounds, phase == PH_PIXELS, rows_done < row_count && row_byte_index < row_len, "row counters out of bounds")
  `BMP24_ASSERT_NEXT(a_eof_rearm, acc && stream.end_of_file, phase == PH_HEADER && byte_position == '0, "end of file did not rearm")
  `BMP24_ASSERT_NEXT(a_emit_shown, acc && emit, result.valid, "result not presented")

endmodule

// ----- tb/bmp24_pixel_sum_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP24 pixel sum unit testbench
// Builds BMP byte streams in memory (good images, broken headers, cut files,
// noise) and sends them through the unit with random gaps and result stalls.
// A local model of the unit predicts each result; results are checked in
// order, field by field.
// ----------------------------------------------------------------------------
module bmp24_pixel_sum_unit_tb;
  import bmp24_pkg::*;

  typedef enum int {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  localparam int unsigned LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  bmp24_in_if  byte_ch ();
  bmp24_out_if result_ch ();

  bmp24_pixel_sum_unit uut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (result_ch)
  );

  // Model state of the unit
  phase_t           mdl_phase;
  logic [31:0]      hdr_pos;
  logic [31:0]      pix_start;
  logic [31:0]      img_w;
  logic [31:0]      img_h;
  logic [15:0]      depth_word;
  int unsigned      row_idx;
  int unsigned      row_len;
  int unsigned      rows_seen;
  int unsigned      row_total;
  logic [SUM_W-1:0] sum_acc;

  result_t    sum_due_q[$];
  result_t    due_r;
  logic [7:0] file_q[$];

  int         mismatch_count = 0;
  int         bytes_accepted = 0;
  int         burst_left     = 0;
  bit         gaps_on        = 1'b1;
  bit         long_hold_req  = 1'b0;
  sink_mode_e sink_mode      = SINK_FREE;

  // --------------------------------------------------------------------------
  // Model of the unit
  // --------------------------------------------------------------------------
  task automatic clear_model();
    mdl_phase  = PH_HEADER;
    hdr_pos    = '0;
    pix_start  = '0;
    img_w      = '0;
    img_h      = '0;
    depth_word = '0;
    row_idx    = 0;
    row_len    = 0;
    rows_seen  = 0;
    row_total  = 0;
    sum_acc    = '0;
  endtask

  // Advance the model by one accepted byte; queue the result it causes
  task automatic predict_file_byte(input logic [7:0] b, input logic eof);
    logic        done;
    status_t     st;
    logic [31:0] habs;
    logic [31:0] p;
    result_t     r;
    done = 1'b0;
    st   = ST_OK;
    case (mdl_phase)
      PH_HEADER: begin
        p = hdr_pos;
        if (p == FIRST_POS) begin
          depth_word = {8'h00, b};
        end else if (p == SIG_HI_POS) begin
          if ({b, depth_word[7:0]} != BMP_SIGNATURE) begin
            done = 1'b1;
            st   = ST_NOT_BMP;
          end
        end else if (p >= OFFSET_POS && p < OFFSET_POS + 4) begin
          pix_start[8*(p - OFFSET_POS) +: 8] = b;
        end else if (p >= WIDTH_POS && p < WIDTH_POS + 4) begin
          img_w[8*(p - WIDTH_POS) +: 8] = b;
        end else if (p >= HEIGHT_POS && p < HEIGHT_POS + 4) begin
          img_h[8*(p - HEIGHT_POS) +: 8] = b;
        end else if (p == DEPTH_POS) begin
          depth_word = {8'h00, b};
        end else if (p == DEPTH_HI_POS) begin
          depth_word[15:8] = b;
        end
        hdr_pos = p + 1;
        // header verdict: depth first, then geometry, then empty image
        if (!done && p == DEPTH_HI_POS) begin
          habs = img_h[31] ? -img_h : img_h;
          if (depth_word != DEPTH_24) begin
            done = 1'b1;
            st   = ST_DEPTH;
          end else if (img_w[31] || img_w > MAX_WIDTH_DEF || habs > MAX_HEIGHT_DEF ||
                       pix_start < HEADER_END) begin
            done = 1'b1;
            st   = ST_GEOM;
          end else if (img_w == 0 || habs == 0) begin
            done = 1'b1;
            st   = ST_OK;
          end else begin
            row_len   = (img_w * 3 + 3) & ~32'd3;
            row_total = habs;
            row_idx   = 0;
            rows_seen = 0;
            sum_acc   = '0;
            mdl_phase = (pix_start == HEADER_END) ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        hdr_pos = hdr_pos + 1;
        if (hdr_pos == pix_start) mdl_phase = PH_PIXELS;
      end
      PH_PIXELS: begin
        // padding bytes past 3*width are not summed
        if (row_idx < img_w * 3) sum_acc = sum_acc + b;
        row_idx++;
        if (row_idx >= row_len) begin
          row_idx = 0;
          rows_seen++;
          if (rows_seen >= row_total) begin
            done = 1'b1;
            st   = ST_OK;
          end
        end
      end
      default: ;
    endcase
    if (!done && eof && mdl_phase != PH_DONE) begin
      done = 1'b1;
      st   = ST_TRUNC;
    end
    if (done) begin
      r.pixel_sum = (st == ST_OK) ? sum_acc : '0;
      r.status    = st;
      sum_due_q.push_back(r);
      mdl_phase = PH_DONE;
    end
    if (eof) clear_model();
  endtask

  // --------------------------------------------------------------------------
  // File building
  // --------------------------------------------------------------------------
  task automatic put_word(input int pos, input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q[pos + k] = v[8*k +: 8];
  endtask

  task automatic add_bytes(input int count, input bit all_ones);
    repeat (count) file_q.push_back(all_ones ? 8'hFF : 8'($urandom));
  endtask

  // Header with random filler, then filler up to the pixel offset
  task automatic start_file(input logic [15:0] sig, input logic [31:0] offset,
                            input logic [31:0] width, input logic [31:0] height,
                            input logic [15:0] depth);
    file_q.delete();
    add_bytes(30, 1'b0);
    file_q[0] = sig[7:0];
    file_q[1] = sig[15:8];
    put_word(OFFSET_POS, offset);
    put_word(WIDTH_POS, width);
    put_word(HEIGHT_POS, height);
    file_q[DEPTH_POS]    = depth[7:0];
    file_q[DEPTH_HI_POS] = depth[15:8];
    // capped so an absurd offset just yields a short file
    while (file_q.size() < offset && file_q.size() < 1024) file_q.push_back(8'($urandom));
  endtask

  function automatic int image_bytes(input logic [31:0] width, input logic [31:0] height);
    logic [31:0] habs;
    habs = height[31] ? -height : height;
    return int'(((width * 3 + 3) & ~32'd3) * habs);
  endfunction

  task automatic make_image(input logic [31:0] offset, input logic [31:0] width,
                            input logic [31:0] height, input bit all_ones);
    start_file(BMP_SIGNATURE, offset, width, height, DEPTH_24);
    add_bytes(image_bytes(width, height), all_ones);
  endtask

  task automatic cut_file(input int len);
    while (file_q.size() > len) void'(file_q.pop_back());
  endtask

  // --------------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (gaps_on && burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                : $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    byte_ch.valid       <= 1'b1;
    byte_ch.file_byte   <= b;
    byte_ch.end_of_file <= eof;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict_file_byte(b, eof);
    bytes_accepted++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  task automatic send_header_case(input logic [15:0] sig, input logic [31:0] offset,
                                  input logic [31:0] width, input logic [31:0] height,
                                  input logic [15:0] depth, input int tail);
    start_file(sig, offset, width, height, depth);
    add_bytes(tail, 1'b0);
    send_file();
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: stall pattern of its own plus the long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_count;
    int tick;
    hold_count      = 0;
    tick            = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_count    = LONG_HOLD;
      end
      tick++;
      if (hold_count > 0) begin
        hold_count--;
        result_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_FREE:   result_ch.ready <= 1'b1;
          SINK_RANDOM: result_ch.ready <= ($urandom_range(0, 9) < 6);
          default:     result_ch.ready <= ((tick % 8) >= 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (sum_due_q.size() == 0) begin
        $error("unexpected result: pixel_sum %0d status %0d",
               result_ch.pixel_sum, result_ch.status);
        mismatch_count++;
      end else begin
        due_r = sum_due_q.pop_front();
        if (result_ch.pixel_sum !== due_r.pixel_sum) begin
          $error("pixel_sum: expected %0d, actual %0d", due_r.pixel_sum, result_ch.pixel_sum);
          mismatch_count++;
        end
        if (result_ch.status !== due_r.status) begin
          $error("status: expected %0d, actual %0d", due_r.status, result_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Bad signature in either byte; file ending on the first and on the bad byte
  task automatic test_signature();
    send_header_case(16'h4D43, 30, 1, 1, DEPTH_24, 4);
    send_header_case(16'hCD42, 30, 1, 1, DEPTH_24, 4);
    file_q = {8'h42};
    send_file();
    file_q = {8'h42, 8'h00};
    send_file();
  endtask

  // Depth not 24, in either byte; depth is reported ahead of bad geometry
  task automatic test_depth();
    send_header_case(BMP_SIGNATURE, 30, 2, 2, 16'd32, 16);
    send_header_case(BMP_SIGNATURE, 30, 2, 2, 16'h0118, 16);
    send_header_case(BMP_SIGNATURE, 20, 32'hFFFF_FFFF, 2, 16'd8, 0);
  endtask

  // Negative or oversize width/height, pixel offset below the header end
  task automatic test_geometry();
    send_header_case(BMP_SIGNATURE, 30, 32'hFFFF_FFFF, 1, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 30, MAX_WIDTH_DEF + 1, 1, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 30, 1, MAX_HEIGHT_DEF + 1, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 30, 1, 32'hFFFF_EFFF, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 30, 1, 32'h8000_0000, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 29, 1, 1, DEPTH_24, 4);
    send_header_case(BMP_SIGNATURE, 0, 1, 1, DEPTH_24, 4);
  endtask

  // Zero width or height: result at the last header byte
  task automatic test_empty();
    send_header_case(BMP_SIGNATURE, 30, 0, 5, DEPTH_24, 0);
    send_header_case(BMP_SIGNATURE, 40, 3, 0, DEPTH_24, 6);
  endtask

  // Every padding size, direct and skipped offsets, bottom-up and top-down rows
  task automatic test_pixels();
    for (int w = 1; w <= 4; w++) begin
      make_image((w % 2) ? 30 : 54, w, (w % 2) ? 32'd2 : -32'sd3, w == 4);
      send_file();
    end
    // bytes after the result are dropped until the end mark
    make_image(30, 2, 1, 1'b0);
    add_bytes(9, 1'b0);
    send_file();
  endtask

  // End mark in the header, the skip area, mid-pixel and on a row's padding
  task automatic test_truncated();
    make_image(30, 4, 2, 1'b0);
    cut_file(15);
    send_file();
    make_image(60, 2, 2, 1'b0);
    cut_file(45);
    send_file();
    make_image(30, 5, 3, 1'b0);
    cut_file(50);
    send_file();
    make_image(30, 1, 2, 1'b0);
    cut_file(34);
    send_file();
  endtask

  // Widest and tallest images the unit accepts
  task automatic test_large();
    gaps_on   = 1'b0;
    sink_mode = SINK_FREE;
    make_image(30, MAX_WIDTH_DEF, 1, 1'b1);
    send_file();
    make_image(54, 1, -MAX_HEIGHT_DEF, 1'b0);
    send_file();
    gaps_on = 1'b1;
  endtask

  // Results held back for a long stretch while bytes keep coming
  task automatic test_backpressure();
    gaps_on       = 1'b0;
    sink_mode     = SINK_FREE;
    long_hold_req = 1'b1;
    repeat (6) begin
      make_image(30, 1, 1, 1'b0);
      send_file();
    end
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed images with random content, some broken and noise files
  task automatic test_random();
    int          first;
    int          files;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    int          k;
    first = bytes_accepted;
    files = 0;
    while (bytes_accepted - first < 450 || files < 40) begin
      w = $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 100);
      h = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 1) h = -h;
      off = ($urandom_range(0, 2) == 0) ? 32'd30 : 32'($urandom_range(31, 70));
      make_image(off, w, h, 1'b0);
      case ($urandom_range(0, 15))
        0: begin
          k = $urandom_range(0, 1);
          file_q[k] = file_q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: begin
          k = $urandom_range(DEPTH_POS, DEPTH_HI_POS);
          file_q[k] = file_q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        2: begin
          case ($urandom_range(0, 3))
            0: file_q[WIDTH_POS + 3] = file_q[WIDTH_POS + 3] | 8'h80;
            1: put_word(WIDTH_POS, $urandom_range(MAX_WIDTH_DEF + 1, 32'h7FFF_FFFF));
            2: put_word(HEIGHT_POS, $urandom_range(MAX_HEIGHT_DEF + 1, 32'hFFFF_FFFF));
            default: put_word(OFFSET_POS, $urandom_range(0, 29));
          endcase
        end
        3: cut_file($urandom_range(1, file_q.size() - 1));
        4: begin
          file_q.delete();
          add_bytes($urandom_range(1, 40), 1'b0);
        end
        default: begin
          if ($urandom_range(0, 2) == 0) add_bytes($urandom_range(1, 4), 1'b0);
        end
      endcase
      if ($urandom_range(0, 3) == 0) sink_mode = sink_mode_e'($urandom_range(0, 2));
      send_file();
      files++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_ch.valid       = 1'b0;
    byte_ch.file_byte   = '0;
    byte_ch.end_of_file = 1'b0;
    clear_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    sink_mode = SINK_PATTERN;
    test_signature();
    test_depth();
    sink_mode = SINK_RANDOM;
    test_geometry();
    test_empty();
    test_pixels();
    test_truncated();
    test_large();
    test_backpressure();
    sink_mode = SINK_RANDOM;
    test_random();

    // drain outstanding results, then wait for the registered result to appear
    byte_ch.valid <= 1'b0;
    sink_mode = SINK_FREE;
    for (int n = 0; n < 5000 && sum_due_q.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sum_due_q.size() != 0) begin
      $error("%0d results never arrived", sum_due_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("bmp24_pixel_sum_unit_tb OK");
    end else begin
      $display("bmp24_pixel_sum_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: 10 ms, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("bmp24_pixel_sum_unit_tb NOT OK");
    $finish;
  end

endmodule
